/* rtl/mf3_pkg.sv */
// mf3_pkg: shared constants for the 3x3 median filter
// register indexes, reset values and the median-of-nine exchange network
// no dependencies
package mf3_pkg;

   localparam int CFG_BITS    = 11;
   localparam int PORT_BITS   = 8;
   localparam int MAX_HEIGHT  = 1024;
   localparam int MIN_DIM     = 3;
   localparam int WIN_TAPS    = 9;
   localparam int NET_STEPS   = 19;

   localparam logic [CFG_BITS-1:0] RESET_DIM = 11'd1024;

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   typedef logic [3:0] tap_index_type;

   // compare-exchange pairs, the NET_LO tap keeps the smaller value
   localparam tap_index_type NET_LO [NET_STEPS] = '{
      4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
      4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
   };
   localparam tap_index_type NET_HI [NET_STEPS] = '{
      4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
      4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
   };

   localparam tap_index_type MEDIAN_TAP = 4'd4;

endpackage

/* rtl/mf3_ram.sv */
// mf3_ram: generic simple dual-port ram, one write and one registered read
// used for the line buffers of the median filter
// no dependencies
module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/median_filter_3x3_top.sv */
// median_filter_3x3_top: streaming 3x3 median filter over a raster pixel stream
// depends on mf3_pkg and mf3_ram (two line buffers)
//
// usage
//   pixels enter on the req_ channel in raster order, one per transfer.
//   for every pixel at row >= 2 and column >= 2 one result leaves on the rsp_
//   channel: the median of the 3x3 window ending at that pixel, i.e. the
//   filtered value of the pixel one row up and one column left. border
//   pixels give no result. rsp_frame_end marks the last result of a frame.
//   image_width and image_height are written on the csr_ channel (index 0
//   and 1) while the block is idle; values are clamped to 3..MAX_WIDTH and
//   3..1024.
//   throughput is one pixel per cycle while rsp_ does not stall: the line buffers
//   are read at the input transfer and written back as stage 1 retires, and the
//   exchange network runs in that same cycle into the result register.
//   stage 1 registers the input transfer; the result register drives rsp_valid.
//   a stalled rsp_ side holds the result register; border pixels still pass, and one
//   further interior pixel is taken into the line-buffer read stage, then req_ready drops.
//   reset clears counters, window and valid flags and restores 1024x1024;
//   line buffer contents stay undefined until the first rows are written.
module median_filter_3x3_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mf3_pkg::PORT_BITS-1:0]       req_pixel_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mf3_pkg::PORT_BITS-1:0]       rsp_median_out,
   output logic                                rsp_frame_end,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  mf3_pkg::reg_index_type              csr_index,
   input  logic [mf3_pkg::CFG_BITS-1:0]        csr_data
);

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int WBITS = $clog2(MAX_WIDTH + 1);
   localparam int CMPW  = (WBITS > mf3_pkg::CFG_BITS) ? WBITS : mf3_pkg::CFG_BITS;
   localparam int HW    = $clog2(mf3_pkg::MAX_HEIGHT);

   typedef logic [PIXEL_BITS-1:0] pixel_type;

   logic [mf3_pkg::CFG_BITS-1:0] width_ff, height_ff;
   logic [AW-1:0]                col_ff, col_in;
   logic [HW-1:0]                row_ff, row_in;

   logic                         s1_valid_ff, s1_emit_ff, s1_last_ff;
   logic [AW-1:0]                s1_col_ff;
   pixel_type                    s1_pix_ff;

   pixel_type                    win_ff [mf3_pkg::WIN_TAPS];
   pixel_type                    win_in [mf3_pkg::WIN_TAPS];

   logic                         rsp_valid_ff;
   pixel_type                    median_ff, median_in;
   logic                         frame_end_ff;

   logic [CMPW-1:0]              cfg_w, eff_w;
   logic [mf3_pkg::CFG_BITS-1:0] eff_h;
   logic                         row_last, frame_last, emit;
   logic                         accept, s1_adv;
   pixel_type                    pix, upper_rd, middle_rd;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mf3_pkg::RESET_DIM;
         height_ff <= mf3_pkg::RESET_DIM;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mf3_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_data;
            mf3_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // effective frame size
   always_comb begin
      cfg_w = CMPW'(width_ff);
      if (cfg_w < CMPW'(mf3_pkg::MIN_DIM)) begin
         eff_w = CMPW'(mf3_pkg::MIN_DIM);
      end else if (cfg_w > CMPW'(MAX_WIDTH)) begin
         eff_w = CMPW'(MAX_WIDTH);
      end else begin
         eff_w = cfg_w;
      end
      if (height_ff < mf3_pkg::CFG_BITS'(mf3_pkg::MIN_DIM)) begin
         eff_h = mf3_pkg::CFG_BITS'(mf3_pkg::MIN_DIM);
      end else if (height_ff > mf3_pkg::CFG_BITS'(mf3_pkg::MAX_HEIGHT)) begin
         eff_h = mf3_pkg::CFG_BITS'(mf3_pkg::MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   assign row_last   = CMPW'(col_ff) >= (eff_w - CMPW'(1));
   assign frame_last = row_last && (mf3_pkg::CFG_BITS'(row_ff) >= (eff_h - 11'd1));
   assign emit       = (row_ff >= HW'(2)) && (col_ff >= AW'(2));

   // handshake
   assign s1_adv    = !s1_emit_ff || !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;
   assign pix       = PIXEL_BITS'(req_pixel_in);

   // position counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_last) begin
            col_in = '0;
            row_in = frame_last ? '0 : row_ff + HW'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
            s1_emit_ff  <= emit;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
            s1_emit_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff  <= col_ff;
         s1_pix_ff  <= pix;
         s1_last_ff <= frame_last;
      end
   end

   // line buffers: read at transfer, written back as stage 1 retires
   mf3_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_upper_line (
      .clock   (clock),
      .wr_en   (s1_valid_ff && s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (middle_rd),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (upper_rd)
   );

   mf3_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_middle_line (
      .clock   (clock),
      .wr_en   (s1_valid_ff && s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (middle_rd)
   );

   // window shift and median network
   always_comb begin
      pixel_type            s [mf3_pkg::WIN_TAPS];
      pixel_type            t;
      mf3_pkg::tap_index_type a, b;
      t = '0;
      for (int k = 0; k < 3; k++) begin
         win_in[k*3]   = win_ff[k*3+1];
         win_in[k*3+1] = win_ff[k*3+2];
      end
      win_in[2] = upper_rd;
      win_in[5] = middle_rd;
      win_in[8] = s1_pix_ff;
      s = win_in;
      for (int n = 0; n < mf3_pkg::NET_STEPS; n++) begin
         a = mf3_pkg::NET_LO[n];
         b = mf3_pkg::NET_HI[n];
         if (s[a] > s[b]) begin
            t    = s[a];
            s[a] = s[b];
            s[b] = t;
         end
      end
      median_in = s[mf3_pkg::MEDIAN_TAP];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < mf3_pkg::WIN_TAPS; k++) begin
            win_ff[k] <= '0;
         end
      end else if (s1_valid_ff && s1_adv) begin
         win_ff <= win_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_valid_ff && s1_emit_ff && s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_emit_ff && s1_adv) begin
         median_ff    <= median_in;
         frame_end_ff <= s1_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_median_out = mf3_pkg::PORT_BITS'(median_ff);
   assign rsp_frame_end  = frame_end_ff;

   // checks
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |-> !req_ready)
      else $error("input taken while stage 1 is stalled");

   a_no_same_address: assert property (@(posedge clock) disable iff (reset)
      accept && s1_valid_ff |-> s1_col_ff != col_ff)
      else $error("line buffer read and write-back at the same column");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && frame_last |=> col_ff == '0 && row_ff == '0)
      else $error("counters did not wrap at end of frame");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_emit_ff && s1_adv |=> rsp_valid)
      else $error("interior pixel retired without a result");

endmodule

/* test/tb_median_filter_3x3_top.sv */
`timescale 1ns / 1ps
// tb_median_filter_3x3_top: self-checking bench for the streaming 3x3 median filter
// a table of frames, then random frames with random sizes, each checked in order
// depends on mf3_pkg and median_filter_3x3_top
module tb_median_filter_3x3_top;
   import mf3_pkg::*;

   localparam int MAX_COLS        = 1024;
   localparam int FILL_COLS       = 64;
   localparam int RANDOM_ITEMS    = 400;
   localparam int RESET_CYCLES    = 8;
   localparam int SETTLE_CYCLES   = 4;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int LIMIT_CYCLES    = 1_500_000;

   typedef struct packed {
      logic [PORT_BITS-1:0] median;
      logic                 frame_end;
   } median_result_type;

   typedef enum logic {
      STEP_CSR   = 1'b0,
      STEP_PIXEL = 1'b1
   } step_kind_type;

   typedef struct packed {
      step_kind_type        kind;
      reg_index_type        index;
      logic [CFG_BITS-1:0]  data;
      logic [PORT_BITS-1:0] pixel;
      logic                 typed;
      logic [PORT_BITS-1:0] exp_median;
      logic                 exp_last;
   } plan_row_type;

   localparam int PLAN_ROWS = 33;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{STEP_CSR,   REG_IMAGE_WIDTH,  11'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{STEP_CSR,   REG_IMAGE_HEIGHT, 11'd2, 8'h00, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'hFF, 1'b1, 8'hFF, 1'b1},
      '{STEP_CSR,   REG_IMAGE_WIDTH,  11'd1, 8'h00, 1'b0, 8'h00, 1'b0},
      '{STEP_CSR,   REG_IMAGE_HEIGHT, 11'd1, 8'h00, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'h00, 1'b1, 8'h00, 1'b1},
      '{STEP_CSR,   REG_IMAGE_WIDTH,  11'd2, 8'h00, 1'b0, 8'h00, 1'b0},
      '{STEP_CSR,   REG_IMAGE_HEIGHT, 11'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'h80, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'h7F, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'h55, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'hAA, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'h01, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'hFE, 1'b0, 8'h00, 1'b0},
      '{STEP_PIXEL, REG_IMAGE_WIDTH,  11'd0, 8'h80, 1'b0, 8'h00, 1'b0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PORT_BITS-1:0] req_pixel_in = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [PORT_BITS-1:0] rsp_median_out;
   logic                 rsp_frame_end;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   reg_index_type        csr_index = REG_IMAGE_WIDTH;
   logic [CFG_BITS-1:0]  csr_data = '0;

   logic [PORT_BITS-1:0] upper_row [MAX_COLS];
   logic [PORT_BITS-1:0] middle_row [MAX_COLS];
   logic [PORT_BITS-1:0] window [WIN_TAPS];
   int unsigned          col_pos = 0;
   int unsigned          row_pos = 0;
   logic [CFG_BITS-1:0]  width_reg = RESET_DIM;
   logic [CFG_BITS-1:0]  height_reg = RESET_DIM;

   median_result_type    pending_medians [$];
   int                   failures = 0;
   int                   results_seen = 0;
   int                   streamed_pixels = 0;
   int                   cycles = 0;
   bit                   steady = 1'b0;
   int                   pixel_style = 0;
   logic [PORT_BITS-1:0] pixel_base = '0;

   median_filter_3x3_top #(
      .MAX_WIDTH  (MAX_COLS),
      .PIXEL_BITS (PORT_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_median_out (rsp_median_out),
      .rsp_frame_end  (rsp_frame_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int unsigned clamp_dim(input logic [CFG_BITS-1:0] v, input int unsigned hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void advance_filter(input logic [PORT_BITS-1:0] pix, output bit emits,
                                          output median_result_type res);
      int unsigned w, h, c, r, ci;
      int i, j;
      logic [PORT_BITS-1:0] sorted [WIN_TAPS];
      logic [PORT_BITS-1:0] t;
      bit row_end;
      w = clamp_dim(width_reg, MAX_COLS);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      c = col_pos;
      r = row_pos;
      ci = (c < MAX_COLS) ? c : MAX_COLS - 1;
      row_end = (c >= w - 1);
      for (i = 0; i < 3; i++) begin
         window[i*3]   = window[i*3+1];
         window[i*3+1] = window[i*3+2];
      end
      window[2] = upper_row[ci];
      window[5] = middle_row[ci];
      window[8] = pix;
      upper_row[ci]  = middle_row[ci];
      middle_row[ci] = pix;
      sorted = window;
      for (i = 0; i < WIN_TAPS - 1; i++) begin
         for (j = i + 1; j < WIN_TAPS; j++) begin
            if (sorted[i] > sorted[j]) begin
               t = sorted[i];
               sorted[i] = sorted[j];
               sorted[j] = t;
            end
         end
      end
      emits = (r >= 2) && (c >= 2);
      res.median = sorted[4];
      res.frame_end = row_end && (r >= h - 1);
      if (row_end) begin
         col_pos = 0;
         row_pos = (r >= h - 1) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [PORT_BITS-1:0] random_pixel();
      case (pixel_style)
         1: begin
            return pixel_base + PORT_BITS'($urandom_range(0, 6));
         end
         2: begin
            return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         end
         default: begin
            return PORT_BITS'($urandom_range(0, 255));
         end
      endcase
   endfunction

   task automatic send_pixel(input logic [PORT_BITS-1:0] pix, input bit typed,
                             input median_result_type typed_res);
      int gap;
      bit emits;
      median_result_type res;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= pix;
      do @(posedge clock); while (!req_ready);
      advance_filter(pix, emits, res);
      if (emits) pending_medians.push_back(typed ? typed_res : res);
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_medians.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input reg_index_type idx, input logic [CFG_BITS-1:0] value);
      drain_block();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_IMAGE_WIDTH) width_reg = value;
      else height_reg = value;
   endtask

   // a cut of zero runs on to the end of the frame
   task automatic stream_frame(input int cut);
      int sent;
      sent = 0;
      do begin
         send_pixel(random_pixel(), 1'b0, '0);
         sent++;
         streamed_pixels++;
      end while (!(col_pos == 0 && row_pos == 0) && sent != cut);
   endtask

   initial begin : stimulus
      median_result_type planned;
      int r;
      for (int i = 0; i < MAX_COLS; i++) begin
         upper_row[i]  = '0;
         middle_row[i] = '0;
      end
      for (int i = 0; i < WIN_TAPS; i++) window[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < PLAN_ROWS; k++) begin
         if (PLAN[k].kind == STEP_CSR) begin
            write_register(PLAN[k].index, PLAN[k].data);
         end else begin
            planned = '{PLAN[k].exp_median, PLAN[k].exp_last};
            send_pixel(PLAN[k].pixel, PLAN[k].typed, planned);
         end
      end

      // one full frame at the widest random width, so every column used later holds pixel data
      pixel_style = 0;
      write_register(REG_IMAGE_WIDTH, CFG_BITS'(FILL_COLS));
      write_register(REG_IMAGE_HEIGHT, 11'd3);
      stream_frame(0);

      streamed_pixels = 0;
      while (streamed_pixels < RANDOM_ITEMS) begin
         steady      = ($urandom_range(0, 3) == 0);
         pixel_style = $urandom_range(0, 2);
         pixel_base  = PORT_BITS'($urandom_range(0, 255));
         if ($urandom_range(0, 3) != 0) begin
            r = $urandom_range(0, 9);
            if (r == 0) write_register(REG_IMAGE_WIDTH, CFG_BITS'($urandom_range(0, 2)));
            else if (r == 1)
               write_register(REG_IMAGE_WIDTH, CFG_BITS'($urandom_range(13, FILL_COLS)));
            else write_register(REG_IMAGE_WIDTH, CFG_BITS'($urandom_range(3, 12)));
         end
         if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 9) == 0)
               write_register(REG_IMAGE_HEIGHT, CFG_BITS'($urandom_range(0, 2)));
            else
               write_register(REG_IMAGE_HEIGHT, CFG_BITS'($urandom_range(3, 8)));
         end
         stream_frame(($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0);
      end
      steady = 1'b0;
      drain_block();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : receiver
      int stall;
      bit held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held && results_seen >= 40) begin
            // long hold-off while the sender keeps offering pixels
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if ($urandom_range(0, 39) == 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(30, 150)) @(posedge clock);
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : scoreboard
      median_result_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_medians.size() == 0) begin
            $error("unexpected transfer: median_out %0d frame_end %0d",
                   rsp_median_out, rsp_frame_end);
            failures++;
         end else begin
            due = pending_medians.pop_front();
            results_seen++;
            if (rsp_median_out !== due.median) begin
               $error("median_out: expected %0d, actual %0d", due.median, rsp_median_out);
               failures++;
            end
            if (rsp_frame_end !== due.frame_end) begin
               $error("frame_end: expected %0d, actual %0d", due.frame_end, rsp_frame_end);
               failures++;
            end
         end
      end
   end

   initial begin : watchdog
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

endmodule

/* filelist.f */
rtl/mf3_pkg.sv
rtl/mf3_ram.sv
rtl/median_filter_3x3_top.sv
test/tb_median_filter_3x3_top.sv
